FILE: sv/spov_pkg.sv
package spov_pkg;

    // Pi with 61 fraction bits, and (4/3)*pi with 40 fraction bits.
    localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;
    localparam logic [42:0] SPH_K = 43'((PI_Q61 >> 19) / 3);
    localparam logic [47:0] VOL_MAX = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        CASE_DISJOINT  = 2'd0,
        CASE_CONTAINED = 2'd1,
        CASE_LENS      = 2'd2
    } case_t;

    typedef struct packed {
        logic signed [23:0] first_center_x;
        logic signed [23:0] first_center_y;
        logic signed [23:0] first_center_z;
        logic [22:0]        first_radius;
        logic signed [23:0] second_center_x;
        logic signed [23:0] second_center_y;
        logic signed [23:0] second_center_z;
        logic [22:0]        second_radius;
    } in_t;

    typedef struct packed {
        case_t       kase;
        logic [23:0] s;
        logic [22:0] g;
        logic [22:0] rmin;
        logic [47:0] d2;
    } front_t;

    typedef struct packed {
        case_t       kase;
        logic [23:0] s;
        logic [22:0] g;
        logic [47:0] vol_sph;
        logic [47:0] d2;
    } geom_t;

    typedef struct packed {
        case_t       kase;
        logic [23:0] s;
        logic [22:0] g;
        logic [47:0] vol_sph;
        logic [23:0] d;
    } root_t;

    typedef struct packed {
        case_t       kase;
        logic [47:0] vol_sph;
        logic [97:0] n;
        logic [35:0] dv;
    } lens_t;

    typedef struct packed {
        case_t       kase;
        logic [47:0] vol_sph;
        logic        ovf;
        logic [63:0] q;
    } quot_t;

    typedef struct packed {
        logic [47:0] overlap_volume;
        case_t       overlap_case;
    } res_t;

endpackage

FILE: sv/sphere_pair_overlap_volume.sv
// Throughput: one request per cycle while the output is not held; the pipeline
// holds 105 requests and a one-entry input skid buffer, so the square root and
// the 64-step divider each spend one stage per result bit.
// Reset: aresetn, synchronous and active low, clears all valid bits and the
// skid buffer; data registers are not reset.
module sphere_pair_overlap_volume
    import spov_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_center_x, first_center_y, first_center_z, first_radius,
    // second_center_x, second_center_y, second_center_z, second_radius, pad
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // overlap_volume, overlap_case, pad
    output logic [55:0]  m_tdata
);

    logic   en;
    logic   skid_valid_reg, skid_valid_next;
    in_t    skid_data_reg;
    in_t    s_data;
    logic   src_valid;
    in_t    src_data;

    logic   front_v, sph_v, sqrt_v, lens_v, div_v;
    front_t front_d;
    geom_t  sph_d;
    root_t  sqrt_d;
    lens_t  lens_d;
    quot_t  div_d;
    res_t   res_d;

    assign s_data.first_center_x  = s_tdata[23:0];
    assign s_data.first_center_y  = s_tdata[47:24];
    assign s_data.first_center_z  = s_tdata[71:48];
    assign s_data.first_radius    = s_tdata[94:72];
    assign s_data.second_center_x = s_tdata[118:95];
    assign s_data.second_center_y = s_tdata[142:119];
    assign s_data.second_center_z = s_tdata[166:143];
    assign s_data.second_radius   = s_tdata[189:167];

    // The whole pipeline advances unless a result is held at the output.
    assign en       = ~m_tvalid | m_tready;
    assign s_tready = ~skid_valid_reg;

    assign src_valid = skid_valid_reg | s_tvalid;
    assign src_data  = skid_valid_reg ? skid_data_reg : s_data;

    always_comb begin
        if (en) begin
            skid_valid_next = 1'b0;
        end else if (s_tvalid && !skid_valid_reg) begin
            skid_valid_next = 1'b1;
        end else begin
            skid_valid_next = skid_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!en && s_tvalid && !skid_valid_reg) begin
            skid_data_reg <= s_data;
        end
    end

    spov_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (src_valid),
        .data_i  (src_data),
        .valid_o (front_v),
        .data_o  (front_d)
    );

    spov_sphere u_sphere (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (front_v),
        .data_i  (front_d),
        .valid_o (sph_v),
        .data_o  (sph_d)
    );

    spov_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (sph_v),
        .data_i  (sph_d),
        .valid_o (sqrt_v),
        .data_o  (sqrt_d)
    );

    spov_lens u_lens (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (sqrt_v),
        .data_i  (sqrt_d),
        .valid_o (lens_v),
        .data_o  (lens_d)
    );

    spov_divide u_divide (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (lens_v),
        .data_i  (lens_d),
        .valid_o (div_v),
        .data_o  (div_d)
    );

    spov_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .valid_i (div_v),
        .data_i  (div_d),
        .valid_o (m_tvalid),
        .data_o  (res_d)
    );

    assign m_tdata = {6'b0, res_d.overlap_case, res_d.overlap_volume};

endmodule

FILE: sv/spov_front.sv
module spov_front
    import spov_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   valid_i,
    input  in_t    data_i,
    output logic   valid_o,
    output front_t data_o
);

    logic               v_reg [4];
    logic signed [24:0] dx_reg, dy_reg, dz_reg;
    logic [23:0]        s_reg [3];
    logic [22:0]        g_reg [3];
    logic [22:0]        rmin_reg [3];
    logic [48:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [47:0]        s2_reg [2];
    logic [45:0]        g2_reg [2];
    logic [49:0]        d2_reg;
    front_t             out_reg;

    logic signed [49:0] px, py, pz;
    case_t              kase_w;

    assign px = dx_reg * dx_reg;
    assign py = dy_reg * dy_reg;
    assign pz = dz_reg * dz_reg;

    always_comb begin
        priority if (d2_reg >= 50'(s2_reg[1])) begin
            kase_w = CASE_DISJOINT;
        end else if (d2_reg <= 50'(g2_reg[1])) begin
            kase_w = CASE_CONTAINED;
        end else begin
            kase_w = CASE_LENS;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) v_reg[i] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= valid_i;
            for (int i = 1; i < 4; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // Differences and radius sum, gap and minimum.
            dx_reg <= $signed({data_i.second_center_x[23], data_i.second_center_x})
                    - $signed({data_i.first_center_x[23], data_i.first_center_x});
            dy_reg <= $signed({data_i.second_center_y[23], data_i.second_center_y})
                    - $signed({data_i.first_center_y[23], data_i.first_center_y});
            dz_reg <= $signed({data_i.second_center_z[23], data_i.second_center_z})
                    - $signed({data_i.first_center_z[23], data_i.first_center_z});
            s_reg[0] <= 24'(data_i.first_radius) + 24'(data_i.second_radius);
            if (data_i.first_radius > data_i.second_radius) begin
                g_reg[0]    <= data_i.first_radius - data_i.second_radius;
                rmin_reg[0] <= data_i.second_radius;
            end else begin
                g_reg[0]    <= data_i.second_radius - data_i.first_radius;
                rmin_reg[0] <= data_i.first_radius;
            end

            // Squares.
            sqx_reg     <= px[48:0];
            sqy_reg     <= py[48:0];
            sqz_reg     <= pz[48:0];
            s2_reg[0]   <= s_reg[0] * s_reg[0];
            g2_reg[0]   <= g_reg[0] * g_reg[0];
            s_reg[1]    <= s_reg[0];
            g_reg[1]    <= g_reg[0];
            rmin_reg[1] <= rmin_reg[0];

            // Squared center distance.
            d2_reg      <= 50'(sqx_reg) + 50'(sqy_reg) + 50'(sqz_reg);
            s2_reg[1]   <= s2_reg[0];
            g2_reg[1]   <= g2_reg[0];
            s_reg[2]    <= s_reg[1];
            g_reg[2]    <= g_reg[1];
            rmin_reg[2] <= rmin_reg[1];

            // Classification.
            out_reg.kase <= kase_w;
            out_reg.s    <= s_reg[2];
            out_reg.g    <= g_reg[2];
            out_reg.rmin <= rmin_reg[2];
            out_reg.d2   <= d2_reg[47:0];
        end
    end

    assign valid_o = v_reg[3];
    assign data_o  = out_reg;

endmodule

FILE: sv/spov_sphere.sv
module spov_sphere
    import spov_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,
    input  logic   valid_i,
    input  front_t data_i,
    output logic   valid_o,
    output geom_t  data_o
);

    logic        v_reg [5];
    front_t      c_reg [4];
    logic [45:0] rr_reg;
    logic [43:0] pk_hh_reg, pk_lh_reg;
    logic [44:0] pk_hl_reg, pk_ll_reg;
    logic [48:0] t_reg;
    logic [47:0] pt_h_reg;
    logic [46:0] pt_l_reg;
    geom_t       out_reg;

    logic [45:0] rr_w;
    logic [88:0] prod_w;
    logic [71:0] b_w;

    assign rr_w   = data_i.rmin * data_i.rmin;
    // rr * SPH_K from four partial products.
    assign prod_w = {pk_hh_reg, 45'b0} + 89'({pk_hl_reg, 23'b0})
                  + 89'({pk_lh_reg, 22'b0}) + 89'(pk_ll_reg);
    assign b_w    = {pt_h_reg, 24'b0} + 72'(pt_l_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 5; i++) v_reg[i] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= valid_i;
            for (int i = 1; i < 5; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rr_reg    <= rr_w;
            c_reg[0]  <= data_i;

            pk_hh_reg <= rr_reg[45:23] * SPH_K[42:22];
            pk_hl_reg <= rr_reg[45:23] * SPH_K[21:0];
            pk_lh_reg <= rr_reg[22:0] * SPH_K[42:22];
            pk_ll_reg <= rr_reg[22:0] * SPH_K[21:0];
            c_reg[1]  <= c_reg[0];

            t_reg     <= prod_w[88:40];
            c_reg[2]  <= c_reg[1];

            pt_h_reg  <= t_reg[48:24] * c_reg[2].rmin;
            pt_l_reg  <= t_reg[23:0] * c_reg[2].rmin;
            c_reg[3]  <= c_reg[2];

            out_reg.kase    <= c_reg[3].kase;
            out_reg.s       <= c_reg[3].s;
            out_reg.g       <= c_reg[3].g;
            out_reg.vol_sph <= b_w[71:24];
            out_reg.d2      <= c_reg[3].d2;
        end
    end

    assign valid_o = v_reg[4];
    assign data_o  = out_reg;

endmodule

FILE: sv/spov_sqrt.sv
module spov_sqrt
    import spov_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  valid_i,
    input  geom_t data_i,
    output logic  valid_o,
    output root_t data_o
);

    localparam int STAGES = 24;

    logic        v_reg   [STAGES];
    logic [47:0] n_reg   [STAGES];
    logic [47:0] res_reg [STAGES];
    geom_t       c_reg   [STAGES];

    // One result bit per stage, most significant first.
    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam logic [47:0] BITV = 48'(1) << (46 - 2 * k);
        logic        v_in;
        logic [47:0] n_in, res_in, trial;
        geom_t       c_in;
        logic        ge;

        if (k == 0) begin : g_first
            assign v_in   = valid_i;
            assign n_in   = data_i.d2;
            assign res_in = '0;
            assign c_in   = data_i;
        end else begin : g_next
            assign v_in   = v_reg[k-1];
            assign n_in   = n_reg[k-1];
            assign res_in = res_reg[k-1];
            assign c_in   = c_reg[k-1];
        end

        assign trial = res_in + BITV;
        assign ge    = n_in >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[k]   <= ge ? n_in - trial : n_in;
                res_reg[k] <= ge ? (res_in >> 1) + BITV : res_in >> 1;
                c_reg[k]   <= c_in;
            end
        end
    end

    assign valid_o        = v_reg[STAGES-1];
    assign data_o.kase    = c_reg[STAGES-1].kase;
    assign data_o.s       = c_reg[STAGES-1].s;
    assign data_o.g       = c_reg[STAGES-1].g;
    assign data_o.vol_sph = c_reg[STAGES-1].vol_sph;
    assign data_o.d       = res_reg[STAGES-1][23:0];

endmodule

FILE: sv/spov_lens.sv
module spov_lens
    import spov_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  valid_i,
    input  root_t data_i,
    output logic  valid_o,
    output lens_t data_o
);

    typedef struct packed {
        case_t       kase;
        logic [47:0] vol_sph;
        logic [35:0] dv;
    } carry_t;

    logic        v_reg [4];
    carry_t      c_reg [3];
    logic [23:0] a_reg;
    logic [47:0] dd_reg, ds_reg;
    logic [45:0] gg_reg;
    logic [47:0] aa_reg;
    logic [49:0] t2_reg;
    logic [48:0] p_hh_reg, p_hl_reg, p_lh_reg, p_ll_reg;
    lens_t       out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) v_reg[i] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= valid_i;
            for (int i = 1; i < 4; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_reg  <= data_i.s - data_i.d;
            dd_reg <= data_i.d * data_i.d;
            ds_reg <= data_i.d * data_i.s;
            gg_reg <= data_i.g * data_i.g;
            // Divisor 12*d, pre-scaled by 256 so the quotient drops 8 fraction bits.
            c_reg[0].dv      <= 36'({data_i.d, 11'b0}) + 36'({data_i.d, 10'b0});
            c_reg[0].kase    <= data_i.kase;
            c_reg[0].vol_sph <= data_i.vol_sph;

            aa_reg   <= a_reg * a_reg;
            t2_reg   <= 50'(dd_reg) + 50'({ds_reg, 1'b0}) - 50'(gg_reg) - 50'({gg_reg, 1'b0});
            c_reg[1] <= c_reg[0];

            p_hh_reg <= aa_reg[47:24] * t2_reg[49:25];
            p_hl_reg <= aa_reg[47:24] * t2_reg[24:0];
            p_lh_reg <= aa_reg[23:0] * t2_reg[49:25];
            p_ll_reg <= aa_reg[23:0] * t2_reg[24:0];
            c_reg[2] <= c_reg[1];

            out_reg.n       <= {p_hh_reg, 49'b0} + 98'({p_hl_reg, 24'b0})
                             + 98'({p_lh_reg, 25'b0}) + 98'(p_ll_reg);
            out_reg.dv      <= c_reg[2].dv;
            out_reg.kase    <= c_reg[2].kase;
            out_reg.vol_sph <= c_reg[2].vol_sph;
        end
    end

    assign valid_o = v_reg[3];
    assign data_o  = out_reg;

endmodule

FILE: sv/spov_divide.sv
module spov_divide
    import spov_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  valid_i,
    input  lens_t data_i,
    output logic  valid_o,
    output quot_t data_o
);

    localparam int QBITS = 64;

    typedef struct packed {
        case_t       kase;
        logic [47:0] vol_sph;
        logic        ovf;
        logic [35:0] dv;
        logic [35:0] rem;
        logic [63:0] nq;
    } div_st_t;

    logic    v_reg  [QBITS+1];
    div_st_t st_reg [QBITS+1];
    div_st_t st0;

    // A quotient of 2^64 or more saturates; otherwise the top part is a
    // valid partial remainder to start the bit loop from.
    always_comb begin
        st0.kase    = data_i.kase;
        st0.vol_sph = data_i.vol_sph;
        st0.ovf     = 36'(data_i.n[97:64]) >= data_i.dv;
        st0.dv      = data_i.dv;
        st0.rem     = 36'(data_i.n[97:64]);
        st0.nq      = data_i.n[63:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0] <= st0;
        end
    end

    for (genvar j = 1; j <= QBITS; j++) begin : g_bit
        div_st_t     st_in, st_nx;
        logic [36:0] trial;
        logic        ge;

        assign st_in = st_reg[j-1];
        assign trial = {st_in.rem, st_in.nq[63]};
        assign ge    = trial >= {1'b0, st_in.dv};

        always_comb begin
            st_nx     = st_in;
            st_nx.rem = ge ? 36'(trial - {1'b0, st_in.dv}) : trial[35:0];
            st_nx.nq  = {st_in.nq[62:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= v_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[j] <= st_nx;
            end
        end
    end

    assign valid_o        = v_reg[QBITS];
    assign data_o.kase    = st_reg[QBITS].kase;
    assign data_o.vol_sph = st_reg[QBITS].vol_sph;
    assign data_o.ovf     = st_reg[QBITS].ovf;
    assign data_o.q       = st_reg[QBITS].nq;

endmodule

FILE: sv/spov_scale.sv
module spov_scale
    import spov_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  valid_i,
    input  quot_t data_i,
    output logic  valid_o,
    output res_t  data_o
);

    typedef struct packed {
        case_t       kase;
        logic [47:0] vol_sph;
        logic        ovf;
    } carry_t;

    logic         v_reg [3];
    carry_t       c_reg [2];
    logic [63:0]  pp_ll_reg, pp_lh_reg, pp_hl_reg, pp_hh_reg;
    logic [50:0]  vol_reg;
    res_t         out_reg;

    logic [127:0] sum_w;

    assign sum_w = {pp_hh_reg, 64'b0} + 128'({pp_hl_reg, 32'b0})
                 + 128'({pp_lh_reg, 32'b0}) + 128'(pp_ll_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) v_reg[i] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= valid_i;
            for (int i = 1; i < 3; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pp_ll_reg        <= data_i.q[31:0] * PI_Q61[31:0];
            pp_lh_reg        <= data_i.q[31:0] * PI_Q61[63:32];
            pp_hl_reg        <= data_i.q[63:32] * PI_Q61[31:0];
            pp_hh_reg        <= data_i.q[63:32] * PI_Q61[63:32];
            c_reg[0].kase    <= data_i.kase;
            c_reg[0].vol_sph <= data_i.vol_sph;
            c_reg[0].ovf     <= data_i.ovf;

            vol_reg  <= sum_w[127:77];
            c_reg[1] <= c_reg[0];

            out_reg.overlap_case <= c_reg[1].kase;
            unique case (c_reg[1].kase)
                CASE_CONTAINED: out_reg.overlap_volume <= c_reg[1].vol_sph;
                CASE_LENS: begin
                    if (c_reg[1].ovf || vol_reg[50:48] != 3'b000) begin
                        out_reg.overlap_volume <= VOL_MAX;
                    end else begin
                        out_reg.overlap_volume <= vol_reg[47:0];
                    end
                end
                default: out_reg.overlap_volume <= '0;
            endcase
        end
    end

    assign valid_o = v_reg[2];
    assign data_o  = out_reg;

endmodule

FILE: bench/tb.sv
module tb
    import spov_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 105;
    localparam int STALL_LIMIT = 20000;
    localparam logic [22:0] RMAX = 23'h7FFFFF;
    localparam logic [23:0] CMAX = 24'h7FFFFF;
    localparam logic [23:0] CMIN = 24'h800000;

    typedef struct {
        logic [47:0] vol;
        case_t       kase;
    } overlap_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [55:0]  m_tdata;

    overlap_t expected_overlaps[$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit hold_sink = 1'b0;
    bit stim_done = 1'b0;

    sphere_pair_overlap_volume u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [47:0] abs_diff_sq(logic [23:0] a, logic [23:0] b);
        logic signed [24:0] t;
        logic [24:0] m;
        t = $signed({b[23], b}) - $signed({a[23], a});
        m = t[24] ? -t : t;
        return 48'(m) * 48'(m);
    endfunction

    function automatic logic [31:0] int_sqrt(logic [63:0] n);
        logic [63:0] res, bit_v;
        res = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > n) bit_v >>= 2;
        while (bit_v != 0) begin
            if (n >= res + bit_v) begin
                n -= res + bit_v;
                res = (res >> 1) + bit_v;
            end else begin
                res >>= 1;
            end
            bit_v >>= 2;
        end
        return res[31:0];
    endfunction

    function automatic overlap_t predict_overlap(in_t p);
        overlap_t o;
        logic [63:0] r1, r2, s, g, d2, r, d, a, t2, tt;
        logic [127:0] w, q;
        r1 = 64'(p.first_radius);
        r2 = 64'(p.second_radius);
        d2 = 64'(abs_diff_sq(p.first_center_x, p.second_center_x))
           + 64'(abs_diff_sq(p.first_center_y, p.second_center_y))
           + 64'(abs_diff_sq(p.first_center_z, p.second_center_z));
        s = r1 + r2;
        g = (r1 > r2) ? r1 - r2 : r2 - r1;
        if (d2 >= s * s) begin
            o.vol = '0;
            o.kase = CASE_DISJOINT;
        end else if (d2 <= g * g) begin
            r = (r1 < r2) ? r1 : r2;
            w = 128'(r * r) * 128'(SPH_K);
            tt = 64'(w >> 40);
            w = 128'(tt) * 128'(r);
            w = w >> 24;
            o.vol = (w > 128'(VOL_MAX)) ? VOL_MAX : w[47:0];
            o.kase = CASE_CONTAINED;
        end else begin
            d = 64'(int_sqrt(d2));
            a = s - d;
            t2 = d * d + 2 * d * s - 3 * g * g;
            q = (128'(a * a) * 128'(t2)) / 128'(12 * d);
            if (q[127:72] != 0) begin
                o.vol = VOL_MAX;
            end else begin
                w = 128'(q[71:8]) * 128'(PI_Q61);
                w = w >> 77;
                o.vol = (w > 128'(VOL_MAX)) ? VOL_MAX : w[47:0];
            end
            o.kase = CASE_LENS;
        end
        return o;
    endfunction

    function automatic int short_gap();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    endfunction

    // Sends one request; a gap may precede it, leaving bubbles in the pipeline.
    task automatic send_pair(in_t p, int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {2'b0, p.second_radius, p.second_center_z, p.second_center_y,
                    p.second_center_x, p.first_radius, p.first_center_z,
                    p.first_center_y, p.first_center_x};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_overlaps.push_back(predict_overlap(p));
    endtask

    task automatic drop_valid();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        drop_valid();
        while (expected_overlaps.size() != 0) @(posedge aclk);
    endtask

    function automatic in_t sphere_pair(logic [23:0] ax, logic [23:0] ay, logic [23:0] az,
                                        logic [22:0] ar, logic [23:0] bx, logic [23:0] by,
                                        logic [23:0] bz, logic [22:0] br);
        in_t p;
        p.first_center_x = ax; p.first_center_y = ay; p.first_center_z = az;
        p.first_radius = ar;
        p.second_center_x = bx; p.second_center_y = by; p.second_center_z = bz;
        p.second_radius = br;
        return p;
    endfunction

    function automatic in_t random_pair();
        in_t p;
        logic [22:0] r1, r2;
        logic [23:0] cx, cy, cz;
        int sel;
        sel = $urandom_range(0, 9);
        cx = 24'($urandom); cy = 24'($urandom); cz = 24'($urandom);
        if (sel < 2) begin
            p = in_t'(190'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
        end else begin
            // Keep centers near each other relative to the radii so that
            // lens and containment cases dominate.
            r1 = (sel < 5) ? 23'($urandom_range(0, 65535)) : 23'($urandom);
            r2 = (sel == 9) ? r1 : ((sel < 5) ? 23'($urandom_range(0, 65535)) : 23'($urandom));
            p = sphere_pair(cx, cy, cz, r1,
                            cx + 24'(int'($urandom_range(0, 2 * r1)) - int'(r1)),
                            cy + 24'(int'($urandom_range(0, 2 * r2)) - int'(r2)),
                            cz + 24'($signed($urandom_range(0, 64)) - 32),
                            r2);
        end
        return p;
    endfunction

    task automatic test_directed();
        send_pair(sphere_pair(0, 0, 0, 0, 0, 0, 0, 0), 0);
        send_pair(sphere_pair(0, 0, 0, RMAX, 0, 0, 0, RMAX), 0);
        send_pair(sphere_pair(0, 0, 0, RMAX, 0, 0, 0, 23'd4096), 0);
        send_pair(sphere_pair(0, 0, 0, 23'd1, 0, 0, 0, RMAX), 1);
        send_pair(sphere_pair(CMIN, CMIN, CMIN, RMAX, CMAX, CMAX, CMAX, RMAX), 0);
        send_pair(sphere_pair(CMAX, CMIN, CMAX, 0, CMIN, CMAX, CMIN, RMAX), 0);
        send_pair(sphere_pair(0, 0, 0, 23'd4096, 24'd4096, 0, 0, 23'd4096), 0);
        send_pair(sphere_pair(0, 0, 0, 23'd4096, 24'd8192, 0, 0, 23'd4096), 0);
        send_pair(sphere_pair(0, 0, 0, 23'd8192, 24'd4096, 0, 0, 23'd4096), 2);
        send_pair(sphere_pair(0, 0, 0, RMAX, 24'd1, 0, 0, RMAX), 0);
        send_pair(sphere_pair(0, 0, 0, RMAX, CMAX, 0, 0, RMAX), 0);
        send_pair(sphere_pair(0, 0, 0, 23'd1, 24'd1, 0, 0, 23'd1), 0);
        send_pair(sphere_pair(24'hFFFFFF, 0, 0, 23'd2, 24'd1, 0, 0, 23'd2), 0);
        send_pair(sphere_pair(CMIN, CMIN, CMIN, RMAX, CMIN, CMIN, CMIN, RMAX), 0);
        send_pair(sphere_pair(CMAX, CMAX, CMAX, RMAX, CMAX, CMAX, CMAX, 0), 0);
        send_pair(sphere_pair(0, 0, 0, 23'h555555, 24'h100000, 24'h100000, 0, 23'h2AAAAA), 0);
        wait_drained();
    endtask

    task automatic test_random_stream(int count);
        repeat (count) send_pair(random_pair(), short_gap());
        wait_drained();
    endtask

    // The sink holds off while requests keep coming, so the pipe fills up.
    task automatic test_backpressure();
        hold_sink = 1'b1;
        fork
            begin
                repeat (400) @(posedge aclk);
                hold_sink = 1'b0;
            end
            repeat (300) send_pair(random_pair(), 0);
        join
        wait_drained();
    endtask

    task automatic test_back_to_back(int count);
        repeat (count) send_pair(random_pair(), 0);
        wait_drained();
    endtask

    always @(posedge aclk) begin
        if (!aresetn || hold_sink) begin
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 29) == 0) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 3) != 0) || stim_done;
        end
    end

    always @(posedge aclk) begin
        overlap_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_overlaps.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                e = expected_overlaps.pop_front();
                if (m_tdata[47:0] !== e.vol || m_tdata[49:48] !== e.kase) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("volume exp %h got %h, case exp %0d got %0d",
                                 e.vol, m_tdata[47:0], e.kase, m_tdata[49:48]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("sphere_pair_overlap_volume: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_stream(900);
        test_backpressure();
        test_back_to_back(300);
        test_random_stream(400);
        stim_done = 1'b1;
        repeat (LATENCY + 20) @(posedge aclk);
        if (mismatches == 0 && expected_overlaps.size() == 0)
            $display("sphere_pair_overlap_volume: match");
        else
            $display("sphere_pair_overlap_volume: mismatch");
        $finish;
    end
endmodule
